// File: hw/rtl/cdf_inverse_sampler_core_macros.svh
// Assertion macros used by the sampler core's RTL.
`ifndef CDF_INVERSE_SAMPLER_CORE_MACROS_SVH
`define CDF_INVERSE_SAMPLER_CORE_MACROS_SVH

// The condition implies the expression in the same cycle.
`define CIS_ASSERT_IMPLIES(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// The condition implies the expression in the following cycle.
`define CIS_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

// File: hw/rtl/cis_pkg.sv
// Types and constants shared by the sampler's modules.
package cis_pkg;

  // Field widths of the transfers and the row width register.
  localparam int KIND_W   = 2;
  localparam int WEIGHT_W = 16;
  localparam int SUM_W    = 28;
  localparam int IDX_W    = 12;
  localparam int STAT_W   = 2;
  localparam int RW_W     = 13;

  // Configuration port geometry.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register word indexes.
  localparam logic [0:0] REG_ROW_WIDTH = 1'b0;

  localparam logic [RW_W-1:0] ROW_WIDTH_RESET = 13'd64;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOP     = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [WEIGHT_W-1:0] weight;
    logic [SUM_W-1:0]    random_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  column_index;
    logic [SUM_W-1:0]  running_total;
    logic [STAT_W-1:0] status;
  } out_item_t;

endpackage

// File: hw/rtl/cis_cdf_mem.sv
// Prefix sum table: one write port and one registered read port.
module cis_cdf_mem import cis_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [SUM_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [SUM_W-1:0] rd_data
);

  logic [SUM_W-1:0] mem [DEPTH];

  // Read data is registered; a read beside a write gets the old data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/cis_divider.sv
// Restoring divider that splits an entry index into row and column, one bit a cycle.
module cis_divider import cis_pkg::*; #(
  parameter int DW = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DW-1:0]   dividend,
  input  logic [RW_W-1:0] divisor,
  output logic            done,
  output logic [DW-1:0]   quotient,
  output logic [RW_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    quo_r;
  logic [RW_W-1:0]  rem_r;
  logic [RW_W-1:0]  dvs_r;
  logic [RW_W:0]    shifted;
  logic [RW_W:0]    diff;
  logic             take;
  logic [RW_W-1:0]  rem_step;
  logic [DW-1:0]    quo_step;

  // One restoring step: shift in the next dividend bit and try a subtraction.
  always_comb begin
    shifted  = {rem_r, quo_r[DW-1]};
    diff     = shifted - {1'b0, dvs_r};
    take     = (shifted >= {1'b0, dvs_r});
    rem_step = take ? diff[RW_W-1:0] : shifted[RW_W-1:0];
    quo_step = DW'({quo_r, take});
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath; the dividend register turns into the quotient as bits shift out.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_step;
      rem_r <= rem_step;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: hw/rtl/cis_apb_regs.sv
// Configuration register file behind the APB-style port.
module cis_apb_regs import cis_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [RW_W-1:0]   row_width
);

  logic [RW_W-1:0] row_width_r;
  logic            wr_row_width;

  // Registers sit on 32-bit words, so byte address bit 2 selects the word.
  assign wr_row_width = psel && penable && pwrite && (paddr[2:2] == REG_ROW_WIDTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RESET;
    end else if (wr_row_width) begin
      row_width_r <= pwdata[RW_W-1:0];
    end
  end

  // Read data; words beyond the register list read as zero.
  always_comb begin
    unique case (paddr[2:2])
      REG_ROW_WIDTH: prdata = APB_DW'(row_width_r);
      default:       prdata = '0;
    endcase
  end

  assign pready    = 1'b1;
  assign row_width = row_width_r;

endmodule

// File: hw/rtl/cdf_inverse_sampler_core.sv
// Inverse-transform sampler core: prefix sum table, binary search and row/column split.
// Load transfers append a weight and store its running prefix sum; loads, restarts and unused
// kinds finish as soon as they are accepted. A sample transfer performs a binary search over
// the prefix sum table with one memory read per cycle, followed by a bit-serial division of
// the found index by row_width and the posting of the result. The single table read port
// and the divider set how long a sample occupies the core. A finished result is held in an
// output register, and the next item is accepted while it waits; if that register is still
// occupied, the result waits in a hold register and the input stalls until the output
// register frees up. Out-of-range samples (zero, above the total, or an empty table) finish
// as soon as they are accepted, with status 1; loads into a full table report status 2. The
// table needs no clearing after reset, since only entries below the fill count are ever read.
`include "cdf_inverse_sampler_core_macros.svh"

module cdf_inverse_sampler_core import cis_pkg::*; #(
  parameter int MAX_ENTRIES = 4096,
  parameter int WEIGHT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int QW = (AW > IDX_W) ? AW : IDX_W;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MASK = (WEIGHT_BITS >= WEIGHT_W) ?
      {WEIGHT_W{1'b1}} : WEIGHT_W'((33'd1 << WEIGHT_BITS) - 33'd1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_PUSH   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [SUM_W-1:0] total_r, total_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    hi_r, hi_nxt;
  logic [CW-1:0]    mid_r, mid_nxt;
  logic [SUM_W-1:0] rand_r, rand_nxt;
  out_item_t        out_r, out_nxt;
  out_item_t        hold_r, hold_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        res;
  logic             fin;
  logic             slot_free;
  logic             accept;
  logic             full;
  logic [SUM_W:0]   load_sum;
  logic [SUM_W-1:0] load_total;
  logic             wr_en;
  logic             rd_en;
  logic [SUM_W-1:0] rd_data;
  logic             ge;
  logic [CW-1:0]    lo_step, hi_step;
  logic [CW:0]      mid_sum;
  logic             div_start, div_done;
  logic [AW-1:0]    div_quot;
  logic [RW_W-1:0]  div_rem;
  logic [RW_W-1:0]  row_width;
  logic [RW_W-1:0]  rw_eff;
  logic [QW-1:0]    row_ext;

  cis_apb_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .row_width (row_width)
  );

  cis_cdf_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (load_total),
    .rd_en   (rd_en),
    .rd_addr (mid_nxt[AW-1:0]),
    .rd_data (rd_data)
  );

  // A row width of zero behaves as one.
  assign rw_eff = (row_width == '0) ? RW_W'(1) : row_width;

  cis_divider #(
    .DW (AW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (lo_step[AW-1:0]),
    .divisor   (rw_eff),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign full      = (count_r == CW'(MAX_ENTRIES));
  assign row_ext   = QW'(div_quot);

  // Saturating running sum for a load.
  always_comb begin
    load_sum   = {1'b0, total_r} + (SUM_W + 1)'(in_item.weight & WEIGHT_MASK);
    load_total = load_sum[SUM_W] ? SUM_MAX : load_sum[SUM_W-1:0];
  end

  // One search step: keep the half that still holds the first entry at or above the draw.
  always_comb begin
    ge      = (rd_data >= rand_r);
    lo_step = ge ? lo_r : (mid_r + CW'(1));
    hi_step = ge ? mid_r : hi_r;
    mid_sum = {1'b0, lo_step} + {1'b0, hi_step};
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    rand_nxt      = rand_r;
    hold_nxt      = hold_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res           = '0;
    fin           = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    div_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res.running_total = total_r;
          case (in_item.kind)
            KIND_LOAD: begin
              fin = 1'b1;
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                wr_en             = 1'b1;
                total_nxt         = load_total;
                count_nxt         = count_r + CW'(1);
                res.running_total = load_total;
              end
            end
            KIND_SAMPLE: begin
              if ((count_r == '0) || (in_item.random_value == '0) ||
                  (in_item.random_value > total_r)) begin
                fin        = 1'b1;
                res.status = STAT_RANGE;
              end else begin
                // First probe covers the whole table.
                lo_nxt    = '0;
                hi_nxt    = count_r;
                mid_nxt   = count_r >> 1;
                rd_en     = 1'b1;
                rand_nxt  = in_item.random_value;
                state_nxt = ST_SEARCH;
              end
            end
            KIND_RESTART: begin
              fin               = 1'b1;
              total_nxt         = '0;
              count_nxt         = '0;
              res.running_total = '0;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        lo_nxt = lo_step;
        hi_nxt = hi_step;
        if (lo_step < hi_step) begin
          mid_nxt = mid_sum[CW:1];
          rd_en   = 1'b1;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          fin                = 1'b1;
          res.row_index      = row_ext[IDX_W-1:0];
          res.column_index   = div_rem[IDX_W-1:0];
          res.running_total  = total_r;
          res.status         = STAT_OK;
        end
      end
      ST_PUSH: begin
        if (slot_free) begin
          out_nxt       = hold_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A finished result goes to the output register, or waits in the hold register.
    if (fin) begin
      if (slot_free) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end else begin
        hold_nxt  = res;
        state_nxt = ST_PUSH;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Search bounds and result payload.
  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    rand_r <= rand_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `CIS_ASSERT_IMPLIES(a_count_bound, 1'b1, count_r <= CW'(MAX_ENTRIES),
      "entry count exceeds table depth")
  `CIS_ASSERT_IMPLIES(a_read_in_table, rd_en, mid_nxt < count_nxt,
      "table read beyond filled entries")
  `CIS_ASSERT_IMPLIES(a_search_range, state_r == ST_SEARCH,
      (lo_r < hi_r) && (hi_r <= count_r) && (mid_r >= lo_r) && (mid_r < hi_r),
      "search bounds inconsistent")
  `CIS_ASSERT_IMPLIES(a_div_done_state, div_done, state_r == ST_DIV,
      "divider finished outside the split phase")
  `CIS_ASSERT_NEXT(a_load_counts, accept && (in_item.kind == KIND_LOAD) && !full,
      count_r == $past(count_r) + CW'(1), "load did not advance the entry count")

endmodule

// File: dv/tb_cdf_inverse_sampler_core.sv
// Self-checking testbench for the CDF inverse sampler core: stream driver, result monitor, predictor.
module tb_cdf_inverse_sampler_core;
  import cis_pkg::*;

  localparam int TABLE_DEPTH = 4096;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [APB_AW-1:0] ROW_WIDTH_ADDR = APB_AW'(4 * REG_ROW_WIDTH);

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_item;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  cdf_inverse_sampler_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Clock with a 10 unit period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus waiting to be offered and results predicted for accepted items.
  in_item_t    queued_items[$];
  out_item_t   predicted_picks[$];
  int          mismatch_count = 0;

  // Idling controls, set between phases.
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_requests = 0;

  // Predictor state: prefix sum table, total, fill count and row width.
  logic [SUM_W-1:0] prefix_table[TABLE_DEPTH];
  logic [SUM_W-1:0] table_total = '0;
  int unsigned      table_count = 0;
  logic [RW_W-1:0]  row_width_cfg = ROW_WIDTH_RESET;

  // Generator's view of the total and count, used to aim sample draws.
  int unsigned      gen_total = 0;
  int unsigned      gen_count = 0;

  // Computes the result of one item and advances the predictor state.
  function automatic out_item_t pick_entry(in_item_t it);
    out_item_t       res;
    logic [SUM_W:0]  sum;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     mid;
    int unsigned     rw;
    res = '0;
    case (it.kind)
      KIND_LOAD: begin
        if (table_count >= TABLE_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          sum = {1'b0, table_total} + (SUM_W + 1)'(it.weight);
          if (sum > {1'b0, SUM_MAX}) sum = {1'b0, SUM_MAX};
          table_total = sum[SUM_W-1:0];
          prefix_table[table_count] = table_total;
          table_count++;
        end
      end
      KIND_SAMPLE: begin
        if (table_count == 0 || it.random_value == '0 || it.random_value > table_total) begin
          res.status = STAT_RANGE;
        end else begin
          // Lower bound search: first entry whose prefix sum reaches the draw.
          lo = 0;
          hi = table_count;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (prefix_table[mid] >= it.random_value) hi = mid;
            else lo = mid + 1;
          end
          rw = (row_width_cfg == '0) ? 1 : row_width_cfg;
          res.row_index    = IDX_W'(lo / rw);
          res.column_index = IDX_W'(lo % rw);
        end
      end
      KIND_RESTART: begin
        table_total = '0;
        table_count = 0;
      end
      default: ;
    endcase
    res.running_total = table_total;
    return res;
  endfunction

  // Driver: records accepted transfers and offers the next queued item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predicted_picks.push_back(pick_entry(in_item));
      if (!in_valid || in_ready) begin
        if (queued_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= queued_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and drives the receiver's stalls.
  int hold_served = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_picks.size() == 0) begin
          $display("%0t: result with nothing expected: %p", $time, out_item);
          mismatch_count++;
        end else begin
          want = predicted_picks.pop_front();
          if (out_item.row_index !== want.row_index) begin
            $display("%0t: row_index expected %0d, actual %0d",
                     $time, want.row_index, out_item.row_index);
            mismatch_count++;
          end
          if (out_item.column_index !== want.column_index) begin
            $display("%0t: column_index expected %0d, actual %0d",
                     $time, want.column_index, out_item.column_index);
            mismatch_count++;
          end
          if (out_item.running_total !== want.running_total) begin
            $display("%0t: running_total expected %0d, actual %0d",
                     $time, want.running_total, out_item.running_total);
            mismatch_count++;
          end
          if (out_item.status !== want.status) begin
            $display("%0t: status expected %0d, actual %0d",
                     $time, want.status, out_item.status);
            mismatch_count++;
          end
        end
      end
      // A long hold-off lets the core fill up and stall its input.
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Queues one item and tracks the total it leaves behind.
  task automatic queue_item(logic [KIND_W-1:0] kind, logic [WEIGHT_W-1:0] w, int unsigned r);
    in_item_t it;
    it.kind = kind;
    it.weight = w;
    it.random_value = SUM_W'(r);
    queued_items.push_back(it);
    if (kind == KIND_LOAD && gen_count < TABLE_DEPTH) begin
      gen_total = gen_total + w;
      if (gen_total > int'(SUM_MAX)) gen_total = int'(SUM_MAX);
      gen_count++;
    end else if (kind == KIND_RESTART) begin
      gen_total = 0;
      gen_count = 0;
    end
  endtask

  // Picks a draw, mostly inside 1..total, sometimes at or past its edges.
  function automatic int unsigned pick_draw();
    int x;
    x = $urandom_range(99);
    if (x < 82 && gen_total > 0) return $urandom_range(gen_total, 1);
    if (x < 86) return 0;
    if (x < 90) return gen_total;
    if (x < 94) return gen_total + 1;
    return $urandom() & int'(SUM_MAX);
  endfunction

  // Random traffic: mostly restart, load a table, then sample it; some noise.
  // Exactly n items are queued.
  task automatic queue_random(int n);
    int made;
    int nload;
    int nsamp;
    int wmode;
    int x;
    logic [WEIGHT_W-1:0] w;
    made = 0;
    while (made < n) begin
      if ($urandom_range(99) < 10) begin
        queue_item(KIND_W'($urandom_range(3)), WEIGHT_W'($urandom()), $urandom());
        made++;
      end else begin
        if ($urandom_range(99) < 80) begin
          queue_item(KIND_RESTART, WEIGHT_W'($urandom()), $urandom());
          made++;
        end
        x = $urandom_range(99);
        nload = (x < 75) ? $urandom_range(20, 1) :
                (x < 95) ? $urandom_range(150, 21) : $urandom_range(400, 151);
        wmode = $urandom_range(2);
        for (int i = 0; i < nload && made < n; i++) begin
          case (wmode)
            0:       w = WEIGHT_W'($urandom_range(15));
            1:       w = WEIGHT_W'($urandom());
            default: w = ($urandom_range(3) == 0) ? '0 : WEIGHT_W'($urandom_range(300, 1));
          endcase
          queue_item(KIND_LOAD, w, $urandom());
          made++;
        end
        nsamp = $urandom_range(25, 1);
        for (int i = 0; i < nsamp && made < n; i++) begin
          if ($urandom_range(99) < 5) queue_item(KIND_LOAD, WEIGHT_W'($urandom()), $urandom());
          else queue_item(KIND_SAMPLE, WEIGHT_W'($urandom()), pick_draw());
          made++;
        end
      end
    end
  endtask

  // Waits until every queued item has been accepted and every result has arrived.
  // Sampled at the falling edge so that the driver's updates have settled.
  task automatic wait_drained();
    while (queued_items.size() > 0 || in_valid || predicted_picks.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_row_width(logic [RW_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROW_WIDTH_ADDR;
    pwdata  <= APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    row_width_cfg = v;
  endtask

  // Starts a phase on an idle core: new row width and idling mix.
  task automatic start_phase(logic [RW_W-1:0] rw, int sidle, int rstall);
    wait_drained();
    write_row_width(rw);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
  endtask

  // Run-away guard.
  initial begin
    #10_000_000;
    $display("tb_cdf_inverse_sampler_core: done, errors");
    $finish;
  end

  // Reset, directed items, then random phases.
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_ready = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, no-op kind, extreme weights, draw edges, restart.
    queue_item(KIND_SAMPLE, '1, 1);
    queue_item(KIND_NOP, '1, int'(SUM_MAX));
    queue_item(KIND_LOAD, '0, int'(SUM_MAX));
    queue_item(KIND_LOAD, '1, 0);
    queue_item(KIND_LOAD, 16'd1, 0);
    queue_item(KIND_SAMPLE, '0, 0);
    queue_item(KIND_SAMPLE, '0, 1);
    queue_item(KIND_SAMPLE, '0, 65535);
    queue_item(KIND_SAMPLE, '0, 65536);
    queue_item(KIND_SAMPLE, '0, 65537);
    queue_item(KIND_SAMPLE, '0, int'(SUM_MAX));
    queue_item(KIND_NOP, '0, 0);
    queue_item(KIND_RESTART, '1, int'(SUM_MAX));
    queue_item(KIND_SAMPLE, '0, 1);
    queue_item(KIND_LOAD, 16'd5, 0);
    queue_item(KIND_SAMPLE, '0, 5);
    queue_item(KIND_SAMPLE, '0, 6);
    queue_item(KIND_LOAD, '0, 0);
    queue_item(KIND_SAMPLE, '0, 5);

    // Random phases with different row widths and idling mixes.
    start_phase(13'd1, 0, 0);
    queue_random(170);
    start_phase(13'd0, 47, 0);
    queue_random(170);
    start_phase(13'h1FFF, 0, 47);
    queue_random(170);
    hold_requests++;
    start_phase(13'd3, 24, 24);
    queue_random(170);
    start_phase(13'd4096, 0, 0);
    queue_random(170);

    // The last table again, split one entry per row, then fresh random traffic.
    start_phase(13'd1, 0, 47);
    queue_item(KIND_SAMPLE, '0, gen_total);
    queue_item(KIND_SAMPLE, '0, 1);
    for (int i = 0; i < 20; i++) queue_item(KIND_SAMPLE, WEIGHT_W'($urandom()), pick_draw());
    queue_random(130);
    hold_requests++;

    start_phase(RW_W'($urandom_range(200, 2)), 24, 24);
    queue_random(130);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("tb_cdf_inverse_sampler_core: done, clean");
    end else begin
      $display("tb_cdf_inverse_sampler_core: done, errors");
    end
    $finish;
  end

endmodule

// File: cdf_inverse_sampler_core.f
+incdir+hw/rtl
hw/rtl/cis_pkg.sv
hw/rtl/cis_cdf_mem.sv
hw/rtl/cis_divider.sv
hw/rtl/cis_apb_regs.sv
hw/rtl/cdf_inverse_sampler_core.sv
dv/tb_cdf_inverse_sampler_core.sv
